// File: rtl/assert_macros.svh
// Assertion macros shared by the NMEA sentence framer RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define NSF_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define NSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/nsf_pkg.sv
// Package for the NMEA sentence framer: sizes, characters, state and result types.
// No dependencies.
`default_nettype none

package nsf_pkg;

  localparam int BUFFER_BYTES = 512;
  localparam int CNT_W        = $clog2(BUFFER_BYTES);
  localparam int LEN_W        = 10;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(BUFFER_BYTES - 5);
  localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(BUFFER_BYTES - 3);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_COLLECT = 4'b0010,
    ST_STAR    = 4'b0100,
    ST_CS1     = 4'b1000
  } frame_state_t;

  typedef struct packed {
    logic             byte_stored;
    logic             sentence_restart;
    logic             sentence_aborted;
    logic             sentence_done;
    logic             checksum_ok;
    logic [LEN_W-1:0] sentence_length;
  } result_t;

  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'hA) ? (8'h30 + wide) : (8'h37 + wide);
  endfunction

endpackage

`default_nettype wire

// File: rtl/nsf_channels.sv
// Valid/ready channels of the NMEA sentence framer: received bytes in, results out.
// Depends on nsf_pkg for the length width.
`default_nettype none

interface nsf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsf_res_if;
  logic                     valid;
  logic                     ready;
  logic                     byte_stored;
  logic                     sentence_restart;
  logic                     sentence_aborted;
  logic                     sentence_done;
  logic                     checksum_ok;
  logic [nsf_pkg::LEN_W-1:0] sentence_length;

  modport source (output valid, output byte_stored, output sentence_restart,
                  output sentence_aborted, output sentence_done, output checksum_ok,
                  output sentence_length, input ready);
  modport sink (input valid, input byte_stored, input sentence_restart,
                input sentence_aborted, input sentence_done, input checksum_ok,
                input sentence_length, output ready);
endinterface

`default_nettype wire

// File: rtl/nsf_framer.sv
// Sentence framing state: running XOR, byte count and checksum compare per byte.
// Depends on nsf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nsf_framer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  output nsf_pkg::result_t      res_next
);

  nsf_pkg::frame_state_t          state, state_next;
  logic [nsf_pkg::CNT_W-1:0]      count, count_next;
  logic [7:0]                     run_xor, run_xor_next;
  logic [7:0]                     first_char, first_char_next;
  logic [nsf_pkg::CNT_W-1:0]      count_inc;

  assign count_inc = count + nsf_pkg::CNT_W'(1);

  always_comb begin
    state_next      = state;
    count_next      = count;
    run_xor_next    = run_xor;
    first_char_next = first_char;
    res_next        = '0;
    case (state)
      nsf_pkg::ST_IDLE: begin
        if (rx_byte == nsf_pkg::CH_DOLLAR) begin
          state_next                = nsf_pkg::ST_COLLECT;
          count_next                = nsf_pkg::CNT_W'(1);
          run_xor_next              = 8'h00;
          res_next.byte_stored      = 1'b1;
          res_next.sentence_restart = 1'b1;
        end
      end
      nsf_pkg::ST_COLLECT: begin
        if (rx_byte == nsf_pkg::CH_DOLLAR) begin
          count_next                = nsf_pkg::CNT_W'(1);
          run_xor_next              = 8'h00;
          res_next.byte_stored      = 1'b1;
          res_next.sentence_restart = 1'b1;
        end else if (count >= nsf_pkg::COUNT_LIMIT) begin
          state_next                = nsf_pkg::ST_IDLE;
          count_next                = '0;
          res_next.sentence_aborted = 1'b1;
        end else begin
          count_next           = count_inc;
          res_next.byte_stored = 1'b1;
          if (rx_byte == nsf_pkg::CH_STAR) begin
            state_next = nsf_pkg::ST_STAR;
          end else begin
            run_xor_next = run_xor ^ rx_byte;
          end
        end
      end
      nsf_pkg::ST_STAR: begin
        first_char_next      = rx_byte;
        count_next           = count_inc;
        res_next.byte_stored = 1'b1;
        state_next           = nsf_pkg::ST_CS1;
      end
      nsf_pkg::ST_CS1: begin
        res_next.byte_stored     = 1'b1;
        res_next.sentence_done   = 1'b1;
        res_next.checksum_ok     =
          (nsf_pkg::hex_upper(run_xor[7:4]) == first_char) &&
          (nsf_pkg::hex_upper(run_xor[3:0]) == rx_byte);
        res_next.sentence_length = nsf_pkg::LEN_W'(count_inc);
        state_next               = nsf_pkg::ST_IDLE;
        count_next               = '0;
      end
      default: begin
        state_next = nsf_pkg::ST_IDLE;
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= nsf_pkg::ST_IDLE;
      count      <= '0;
      run_xor    <= 8'h00;
      first_char <= 8'h00;
    end else if (step) begin
      state      <= state_next;
      count      <= count_next;
      run_xor    <= run_xor_next;
      first_char <= first_char_next;
    end
  end

  `NSF_ASSERT_ALWAYS(a_idle_count_zero, clk, rst || (state != nsf_pkg::ST_IDLE) || (count == '0), "idle with nonzero byte count")
  `NSF_ASSERT_RST(a_count_bound, clk, rst, count <= nsf_pkg::COUNT_MAX, "byte count beyond buffer bound")
  `NSF_ASSERT_RST(a_restart_clears, clk, rst, (step && res_next.sentence_restart) |=> (count == nsf_pkg::CNT_W'(1)) && (run_xor == 8'h00), "restart did not reset count and xor")
  `NSF_ASSERT_RST(a_done_to_idle, clk, rst, (step && (res_next.sentence_done || res_next.sentence_aborted)) |=> (state == nsf_pkg::ST_IDLE), "sentence end did not return to idle")

endmodule

`default_nettype wire

// File: rtl/nmea_sentence_framer_top.sv
// NMEA sentence framer, top level: takes one received byte per transfer and returns
// one result per byte. Accepts a byte every cycle while the result channel is ready; a
// byte's result passes through the input register, then the result register, and its
// transfer is limited only by the result channel's ready.
// Depends on nsf_pkg, nsf_channels, nsf_framer, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nmea_sentence_framer_top (
  input  wire logic clk,
  input  wire logic rst,
  nsf_rx_if.sink    rx,
  nsf_res_if.source res
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              out_valid;
  nsf_pkg::result_t  result;
  nsf_pkg::result_t  res_next;
  logic              out_free;
  logic              step;

  assign out_free = !out_valid || res.ready;
  assign step     = in_valid && out_free;
  assign rx.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  nsf_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (in_byte),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= res_next;
    end
  end

  assign res.valid            = out_valid;
  assign res.byte_stored      = result.byte_stored;
  assign res.sentence_restart = result.sentence_restart;
  assign res.sentence_aborted = result.sentence_aborted;
  assign res.sentence_done    = result.sentence_done;
  assign res.checksum_ok      = result.checksum_ok;
  assign res.sentence_length  = result.sentence_length;

  `NSF_ASSERT_RST(a_in_hold, clk, rst, (in_valid && !out_free) |=> in_valid && $stable(in_byte), "input register lost a stalled byte")
  `NSF_ASSERT_RST(a_step_fills, clk, rst, step |=> out_valid, "processed byte produced no result")
  `NSF_ASSERT_RST(a_no_step_empty, clk, rst, !in_valid |-> !step, "framer advanced without a byte")

endmodule

`default_nettype wire
